FILE: design/sef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_pkg
// Types, register indexes, widths and helper functions shared by the bar
// force pipeline.
// ----------------------------------------------------------------------------
package sef_pkg;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [15:0]        member_width;
        logic [31:0]        rest_length;
    } sef_in_t;

    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic [31:0]        stress_ratio;
        logic [31:0]        current_length;
        logic [1:0]         error_code;
    } sef_out_t;

    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 40;
    localparam logic [CfgIdxW-1:0] RegModulus = 8'd0;
    localparam logic [CfgIdxW-1:0] RegYield   = 8'd1;
    localparam logic [39:0] ModulusReset = 40'd210000000000;
    localparam logic [31:0] YieldReset   = 32'd355000000;

    localparam logic [1:0] ErrNone     = 2'd0;
    localparam logic [1:0] ErrRestZero = 2'd1;
    localparam logic [1:0] ErrLenZero  = 2'd2;

    // Square root: 66-bit radicand, 33-bit root, 34-bit partial remainder.
    localparam int SqW    = 66;
    localparam int LenW   = 33;
    localparam int RemW   = 34;

    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic        sx;
        logic        sy;
        logic [71:0] ew;
        logic [31:0] r;
    } sq_side_t;

    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic        sx;
        logic        sy;
        logic        dneg;
        logic [32:0] len;
        logic        rz;
        logic [88:0] sn;
        logic [63:0] sd;
    } fm_side_t;

    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic        negx;
        logic        negy;
        logic [32:0] len;
        logic        rz;
        logic        ovf;
        logic        snz;
        logic [88:0] fm;
    } st_side_t;

    typedef struct packed {
        logic        negx;
        logic        negy;
        logic [32:0] len;
        logic        rz;
        logic [31:0] stress;
        logic        ovf;
    } xy_side_t;

    // Signed saturation of a force magnitude; ovf flags a quotient of 2^64 or more.
    function automatic logic [63:0] sat_force(logic [63:0] q, logic ovf, logic neg);
        logic [63:0] res;
        if (neg) begin
            if (ovf || q > 64'h8000_0000_0000_0000) res = 64'h8000_0000_0000_0000;
            else res = 64'd0 - q;
        end else begin
            if (ovf || q[63]) res = 64'h7FFF_FFFF_FFFF_FFFF;
            else res = q;
        end
        return res;
    endfunction

endpackage

FILE: design/sef_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_sqrt_cell
// One digit step of the integer square root: takes two radicand bits and
// decides one root bit, then hands the word on to the next cell.
// ----------------------------------------------------------------------------
module sef_sqrt_cell #(
    parameter int SW = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      v_in,
    input  logic [sef_pkg::RemW-1:0]  rem_in,
    input  logic [sef_pkg::LenW-1:0]  root_in,
    input  logic [sef_pkg::SqW-1:0]   val_in,
    input  logic [SW-1:0]             side_in,
    output logic                      v_out,
    output logic [sef_pkg::RemW-1:0]  rem_out,
    output logic [sef_pkg::LenW-1:0]  root_out,
    output logic [sef_pkg::SqW-1:0]   val_out,
    output logic [SW-1:0]             side_out
);

    logic [sef_pkg::RemW+1:0] t;
    logic [sef_pkg::RemW+1:0] trial;
    logic [sef_pkg::RemW+1:0] diff;
    logic                     ge;
    logic                     v_reg;
    logic [sef_pkg::RemW-1:0] rem_reg;
    logic [sef_pkg::LenW-1:0] root_reg;
    logic [sef_pkg::SqW-1:0]  val_reg;
    logic [SW-1:0]            side_reg;

    assign t     = {rem_in, val_in[sef_pkg::SqW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= ge ? diff[sef_pkg::RemW-1:0] : t[sef_pkg::RemW-1:0];
            root_reg <= {root_in[sef_pkg::LenW-2:0], ge};
            val_reg  <= {val_in[sef_pkg::SqW-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign val_out  = val_reg;
    assign side_out = side_reg;

endmodule

FILE: design/sef_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_div_cell
// One restoring division step. The numerator shifts out at the top of nq
// while quotient bits shift in at the bottom, so after NW cells nq holds the
// quotient.
// ----------------------------------------------------------------------------
module sef_div_cell #(
    parameter int DW = 32,
    parameter int NW = 32,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          v_in,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] nq_in,
    input  logic [DW-1:0] d_in,
    input  logic [SW-1:0] side_in,
    output logic          v_out,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] nq_out,
    output logic [DW-1:0] d_out,
    output logic [SW-1:0] side_out
);

    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic          v_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] nq_reg;
    logic [DW-1:0] d_reg;
    logic [SW-1:0] side_reg;

    assign t    = {rem_in, nq_in[NW-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = t >= {1'b0, d_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= ge ? diff[DW-1:0] : t[DW-1:0];
            nq_reg   <= {nq_in[NW-2:0], ge};
            d_reg    <= d_in;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign d_out    = d_reg;
    assign side_out = side_reg;

endmodule

FILE: design/spring_edge_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_edge_force
// Axial spring force, stress ratio and current length of one truss bar per
// word, computed in a pipeline of square root and division cells.
// ----------------------------------------------------------------------------
//  Port group | Direction | Carries
//  s_*        | in        | bar word: end positions, width, rest length
//  m_*        | out       | result word: force vector, stress ratio, length, error
//  cfg_*      | in        | register writes: index 0 modulus, index 1 yield
//
//  One word is taken every cycle while s_ready is high; its result passes the
//  cell rows in turn: 33 root cells, 89 force division cells, 32 stress
//  division cells and two side-by-side rows of 64 component division cells,
//  with 12 glue stages between them and the output register at the end.
//  Reset clears the valid flags and loads the default register values.
//  A stalled output parks one word in a skid register; s_ready drops while it
//  is full and the whole pipeline holds.
// ----------------------------------------------------------------------------
module spring_edge_force (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sef_pkg::sef_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sef_pkg::sef_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sef_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [sef_pkg::CfgDataW-1:0]  cfg_data
);

    localparam int SqSteps = 33;
    localparam int FmSteps = 89;
    localparam int StSteps = 32;
    localparam int XySteps = 64;
    localparam int SqSW = $bits(sef_pkg::sq_side_t);
    localparam int FmSW = $bits(sef_pkg::fm_side_t);
    localparam int StSW = $bits(sef_pkg::st_side_t);
    localparam int XySW = $bits(sef_pkg::xy_side_t);

    logic        en;
    logic [39:0] modulus_reg;
    logic [31:0] yield_reg;

    // ---------------- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= sef_pkg::ModulusReset;
            yield_reg   <= sef_pkg::YieldReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                sef_pkg::RegModulus: modulus_reg <= cfg_data;
                sef_pkg::RegYield:   yield_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage a: differences and magnitudes
    logic        a_v_reg;
    logic [32:0] a_ax_reg, a_ay_reg;
    logic        a_sx_reg, a_sy_reg;
    logic [15:0] a_w_reg;
    logic [31:0] a_r_reg;
    logic [32:0] dx, dy;

    assign dx = {s_data.start_x[31], s_data.start_x} - {s_data.end_x[31], s_data.end_x};
    assign dy = {s_data.start_y[31], s_data.start_y} - {s_data.end_y[31], s_data.end_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) a_v_reg <= 1'b0;
        else if (en)  a_v_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ax_reg <= dx[32] ? 33'd0 - dx : dx;
            a_ay_reg <= dy[32] ? 33'd0 - dy : dy;
            a_sx_reg <= dx[32];
            a_sy_reg <= dy[32];
            a_w_reg  <= s_data.member_width;
            a_r_reg  <= s_data.rest_length;
        end
    end

    // ---------------- stage b: squares
    logic        b_v_reg;
    logic [65:0] b_axx_reg, b_ayy_reg;
    logic [31:0] b_ww_reg;
    logic [32:0] b_ax_reg, b_ay_reg;
    logic        b_sx_reg, b_sy_reg;
    logic [31:0] b_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) b_v_reg <= 1'b0;
        else if (en)  b_v_reg <= a_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_axx_reg <= a_ax_reg * a_ax_reg;
            b_ayy_reg <= a_ay_reg * a_ay_reg;
            b_ww_reg  <= a_w_reg * a_w_reg;
            b_ax_reg  <= a_ax_reg;
            b_ay_reg  <= a_ay_reg;
            b_sx_reg  <= a_sx_reg;
            b_sy_reg  <= a_sy_reg;
            b_r_reg   <= a_r_reg;
        end
    end

    // ---------------- stage c: sum of squares, modulus times width squared
    logic        c_v_reg;
    logic [65:0] c_sq_reg;
    logic [63:0] c_ewl_reg;
    logic [39:0] c_ewh_reg;
    logic [32:0] c_ax_reg, c_ay_reg;
    logic        c_sx_reg, c_sy_reg;
    logic [31:0] c_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) c_v_reg <= 1'b0;
        else if (en)  c_v_reg <= b_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_sq_reg  <= b_axx_reg + b_ayy_reg;
            c_ewl_reg <= modulus_reg[31:0] * b_ww_reg;
            c_ewh_reg <= modulus_reg[39:32] * b_ww_reg;
            c_ax_reg  <= b_ax_reg;
            c_ay_reg  <= b_ay_reg;
            c_sx_reg  <= b_sx_reg;
            c_sy_reg  <= b_sy_reg;
            c_r_reg   <= b_r_reg;
        end
    end

    // ---------------- stage d: feed the root row
    logic              d_v_reg;
    logic [65:0]       d_sq_reg;
    sef_pkg::sq_side_t d_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) d_v_reg <= 1'b0;
        else if (en)  d_v_reg <= c_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_sq_reg      <= c_sq_reg;
            d_side_reg.ax <= c_ax_reg;
            d_side_reg.ay <= c_ay_reg;
            d_side_reg.sx <= c_sx_reg;
            d_side_reg.sy <= c_sy_reg;
            d_side_reg.ew <= {c_ewh_reg, 32'd0} + {8'd0, c_ewl_reg};
            d_side_reg.r  <= c_r_reg;
        end
    end

    // ---------------- square root row
    logic                     sq_v    [0:SqSteps];
    logic [sef_pkg::RemW-1:0] sq_rem  [0:SqSteps];
    logic [sef_pkg::LenW-1:0] sq_root [0:SqSteps];
    logic [sef_pkg::SqW-1:0]  sq_val  [0:SqSteps];
    logic [SqSW-1:0]          sq_side [0:SqSteps];

    assign sq_v[0]    = d_v_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_val[0]  = d_sq_reg;
    assign sq_side[0] = d_side_reg;

    for (genvar i = 0; i < SqSteps; i++) begin : g_sq
        sef_sqrt_cell #(.SW(SqSW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .v_in(sq_v[i]), .rem_in(sq_rem[i]), .root_in(sq_root[i]),
            .val_in(sq_val[i]), .side_in(sq_side[i]),
            .v_out(sq_v[i+1]), .rem_out(sq_rem[i+1]), .root_out(sq_root[i+1]),
            .val_out(sq_val[i+1]), .side_out(sq_side[i+1])
        );
    end

    // ---------------- stage e: length difference
    sef_pkg::sq_side_t e_in;
    logic [32:0]       e_len;
    logic              e_dneg;
    logic              e_v_reg;
    sef_pkg::sq_side_t e_side_reg;
    logic [32:0]       e_len_reg, e_ad_reg;
    logic              e_dneg_reg;

    assign e_in   = sef_pkg::sq_side_t'(sq_side[SqSteps]);
    assign e_len  = sq_root[SqSteps];
    assign e_dneg = e_len < {1'b0, e_in.r};

    always_ff @(posedge aclk) begin
        if (!aresetn) e_v_reg <= 1'b0;
        else if (en)  e_v_reg <= sq_v[SqSteps];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg <= e_in;
            e_len_reg  <= e_len;
            e_dneg_reg <= e_dneg;
            e_ad_reg   <= e_dneg ? {1'b0, e_in.r} - e_len : e_len - {1'b0, e_in.r};
        end
    end

    // ---------------- stage f: partial products
    logic        f_v_reg;
    logic [56:0] f_p0_reg, f_p1_reg, f_p2_reg;
    logic [64:0] f_e0_reg;
    logic [40:0] f_e1_reg;
    logic [63:0] f_sd_reg;
    logic [32:0] f_ax_reg, f_ay_reg, f_len_reg;
    logic        f_sx_reg, f_sy_reg, f_dneg_reg;
    logic [31:0] f_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) f_v_reg <= 1'b0;
        else if (en)  f_v_reg <= e_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_p0_reg   <= e_side_reg.ew[23:0]  * e_ad_reg;
            f_p1_reg   <= e_side_reg.ew[47:24] * e_ad_reg;
            f_p2_reg   <= e_side_reg.ew[71:48] * e_ad_reg;
            f_e0_reg   <= modulus_reg[31:0]  * e_ad_reg;
            f_e1_reg   <= modulus_reg[39:32] * e_ad_reg;
            f_sd_reg   <= e_side_reg.r * yield_reg;
            f_ax_reg   <= e_side_reg.ax;
            f_ay_reg   <= e_side_reg.ay;
            f_sx_reg   <= e_side_reg.sx;
            f_sy_reg   <= e_side_reg.sy;
            f_dneg_reg <= e_dneg_reg;
            f_len_reg  <= e_len_reg;
            f_r_reg    <= e_side_reg.r;
        end
    end

    // ---------------- stage g: sum partial products, feed the force division
    logic [104:0]      g_num;
    logic [72:0]       g_ead;
    logic              g_v_reg;
    logic [88:0]       g_nq_reg;
    logic [31:0]       g_r_reg;
    sef_pkg::fm_side_t g_side_reg;

    assign g_num = {48'd0, f_p0_reg} + {24'd0, f_p1_reg, 24'd0} + {f_p2_reg, 48'd0};
    assign g_ead = {8'd0, f_e0_reg} + {f_e1_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) g_v_reg <= 1'b0;
        else if (en)  g_v_reg <= f_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Dividing by rest length times 2^16 is a shift followed by a division by r.
            g_nq_reg        <= g_num[104:16];
            g_r_reg         <= f_r_reg;
            g_side_reg.ax   <= f_ax_reg;
            g_side_reg.ay   <= f_ay_reg;
            g_side_reg.sx   <= f_sx_reg;
            g_side_reg.sy   <= f_sy_reg;
            g_side_reg.dneg <= f_dneg_reg;
            g_side_reg.len  <= f_len_reg;
            g_side_reg.rz   <= f_r_reg == 32'd0;
            g_side_reg.sn   <= {g_ead, 16'd0};
            g_side_reg.sd   <= f_sd_reg;
        end
    end

    // ---------------- force magnitude division row
    logic            fm_v    [0:FmSteps];
    logic [31:0]     fm_rem  [0:FmSteps];
    logic [88:0]     fm_nq   [0:FmSteps];
    logic [31:0]     fm_d    [0:FmSteps];
    logic [FmSW-1:0] fm_side [0:FmSteps];

    assign fm_v[0]    = g_v_reg;
    assign fm_rem[0]  = '0;
    assign fm_nq[0]   = g_nq_reg;
    assign fm_d[0]    = g_r_reg;
    assign fm_side[0] = g_side_reg;

    for (genvar i = 0; i < FmSteps; i++) begin : g_fm
        sef_div_cell #(.DW(32), .NW(89), .SW(FmSW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .v_in(fm_v[i]), .rem_in(fm_rem[i]), .nq_in(fm_nq[i]),
            .d_in(fm_d[i]), .side_in(fm_side[i]),
            .v_out(fm_v[i+1]), .rem_out(fm_rem[i+1]), .nq_out(fm_nq[i+1]),
            .d_out(fm_d[i+1]), .side_out(fm_side[i+1])
        );
    end

    // ---------------- stage h: stress range check, feed the stress division
    sef_pkg::fm_side_t h_in;
    logic              h_ovf;
    logic              h_v_reg;
    logic [63:0]       h_rem_reg, h_sd_reg;
    logic [31:0]       h_nq_reg;
    sef_pkg::st_side_t h_side_reg;

    assign h_in  = sef_pkg::fm_side_t'(fm_side[FmSteps]);
    // The quotient fits in 32 bits exactly when the top part of the numerator is below sd.
    assign h_ovf = {7'd0, h_in.sn[88:32]} >= h_in.sd;

    always_ff @(posedge aclk) begin
        if (!aresetn) h_v_reg <= 1'b0;
        else if (en)  h_v_reg <= fm_v[FmSteps];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_rem_reg       <= {7'd0, h_in.sn[88:32]};
            h_nq_reg        <= h_in.sn[31:0];
            h_sd_reg        <= h_in.sd;
            h_side_reg.ax   <= h_in.ax;
            h_side_reg.ay   <= h_in.ay;
            h_side_reg.negx <= h_in.dneg ^ h_in.sx;
            h_side_reg.negy <= h_in.dneg ^ h_in.sy;
            h_side_reg.len  <= h_in.len;
            h_side_reg.rz   <= h_in.rz;
            h_side_reg.ovf  <= h_ovf;
            h_side_reg.snz  <= h_in.sn != 89'd0;
            h_side_reg.fm   <= fm_nq[FmSteps];
        end
    end

    // ---------------- stress division row
    logic            st_v    [0:StSteps];
    logic [63:0]     st_rem  [0:StSteps];
    logic [31:0]     st_nq   [0:StSteps];
    logic [63:0]     st_d    [0:StSteps];
    logic [StSW-1:0] st_side [0:StSteps];

    assign st_v[0]    = h_v_reg;
    assign st_rem[0]  = h_rem_reg;
    assign st_nq[0]   = h_nq_reg;
    assign st_d[0]    = h_sd_reg;
    assign st_side[0] = h_side_reg;

    for (genvar i = 0; i < StSteps; i++) begin : g_st
        sef_div_cell #(.DW(64), .NW(32), .SW(StSW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .v_in(st_v[i]), .rem_in(st_rem[i]), .nq_in(st_nq[i]),
            .d_in(st_d[i]), .side_in(st_side[i]),
            .v_out(st_v[i+1]), .rem_out(st_rem[i+1]), .nq_out(st_nq[i+1]),
            .d_out(st_d[i+1]), .side_out(st_side[i+1])
        );
    end

    // ---------------- stage i: force times component, final stress ratio
    sef_pkg::st_side_t i_in;
    logic              i_v_reg;
    logic [62:0]       i_x0_reg, i_x1_reg, i_y0_reg, i_y1_reg;
    logic [61:0]       i_x2_reg, i_y2_reg;
    logic              i_negx_reg, i_negy_reg, i_rz_reg;
    logic [32:0]       i_len_reg;
    logic [31:0]       i_stress_reg;

    assign i_in = sef_pkg::st_side_t'(st_side[StSteps]);

    always_ff @(posedge aclk) begin
        if (!aresetn) i_v_reg <= 1'b0;
        else if (en)  i_v_reg <= st_v[StSteps];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_x0_reg   <= i_in.fm[29:0]  * i_in.ax;
            i_x1_reg   <= i_in.fm[59:30] * i_in.ax;
            i_x2_reg   <= i_in.fm[88:60] * i_in.ax;
            i_y0_reg   <= i_in.fm[29:0]  * i_in.ay;
            i_y1_reg   <= i_in.fm[59:30] * i_in.ay;
            i_y2_reg   <= i_in.fm[88:60] * i_in.ay;
            i_negx_reg <= i_in.negx;
            i_negy_reg <= i_in.negy;
            i_rz_reg   <= i_in.rz;
            i_len_reg  <= i_in.len;
            if (i_in.rz || !i_in.snz) i_stress_reg <= 32'd0;
            else if (i_in.ovf)        i_stress_reg <= 32'hFFFF_FFFF;
            else                      i_stress_reg <= st_nq[StSteps];
        end
    end

    // ---------------- stage j: sum the component products
    logic         j_v_reg;
    logic [121:0] j_nx_reg, j_ny_reg;
    logic         j_negx_reg, j_negy_reg, j_rz_reg;
    logic [32:0]  j_len_reg;
    logic [31:0]  j_stress_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) j_v_reg <= 1'b0;
        else if (en)  j_v_reg <= i_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_nx_reg     <= {59'd0, i_x0_reg} + {29'd0, i_x1_reg, 30'd0} + {i_x2_reg, 60'd0};
            j_ny_reg     <= {59'd0, i_y0_reg} + {29'd0, i_y1_reg, 30'd0} + {i_y2_reg, 60'd0};
            j_negx_reg   <= i_negx_reg;
            j_negy_reg   <= i_negy_reg;
            j_rz_reg     <= i_rz_reg;
            j_len_reg    <= i_len_reg;
            j_stress_reg <= i_stress_reg;
        end
    end

    // ---------------- stage k: range check, feed the component divisions
    logic              k_v_reg;
    logic [32:0]       k_xrem_reg, k_yrem_reg, k_len_reg;
    logic [63:0]       k_xnq_reg, k_ynq_reg;
    sef_pkg::xy_side_t k_side_reg;
    logic              k_ovfy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) k_v_reg <= 1'b0;
        else if (en)  k_v_reg <= j_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_xrem_reg        <= j_nx_reg[96:64];
            k_yrem_reg        <= j_ny_reg[96:64];
            k_xnq_reg         <= j_nx_reg[63:0];
            k_ynq_reg         <= j_ny_reg[63:0];
            k_len_reg         <= j_len_reg;
            k_ovfy_reg        <= j_ny_reg[121:64] >= {25'd0, j_len_reg};
            k_side_reg.negx   <= j_negx_reg;
            k_side_reg.negy   <= j_negy_reg;
            k_side_reg.len    <= j_len_reg;
            k_side_reg.rz     <= j_rz_reg;
            k_side_reg.stress <= j_stress_reg;
            k_side_reg.ovf    <= j_nx_reg[121:64] >= {25'd0, j_len_reg};
        end
    end

    // ---------------- component division rows, x and y side by side
    logic            x_v    [0:XySteps];
    logic [32:0]     x_rem  [0:XySteps];
    logic [63:0]     x_nq   [0:XySteps];
    logic [32:0]     x_d    [0:XySteps];
    logic [XySW-1:0] x_side [0:XySteps];
    logic            y_v    [0:XySteps];
    logic [32:0]     y_rem  [0:XySteps];
    logic [63:0]     y_nq   [0:XySteps];
    logic [32:0]     y_d    [0:XySteps];
    logic            y_side [0:XySteps];

    assign x_v[0]    = k_v_reg;
    assign x_rem[0]  = k_xrem_reg;
    assign x_nq[0]   = k_xnq_reg;
    assign x_d[0]    = k_len_reg;
    assign x_side[0] = k_side_reg;
    assign y_v[0]    = k_v_reg;
    assign y_rem[0]  = k_yrem_reg;
    assign y_nq[0]   = k_ynq_reg;
    assign y_d[0]    = k_len_reg;
    assign y_side[0] = k_ovfy_reg;

    for (genvar i = 0; i < XySteps; i++) begin : g_xy
        sef_div_cell #(.DW(33), .NW(64), .SW(XySW)) u_xcell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .v_in(x_v[i]), .rem_in(x_rem[i]), .nq_in(x_nq[i]),
            .d_in(x_d[i]), .side_in(x_side[i]),
            .v_out(x_v[i+1]), .rem_out(x_rem[i+1]), .nq_out(x_nq[i+1]),
            .d_out(x_d[i+1]), .side_out(x_side[i+1])
        );
        sef_div_cell #(.DW(33), .NW(64), .SW(1)) u_ycell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .v_in(y_v[i]), .rem_in(y_rem[i]), .nq_in(y_nq[i]),
            .d_in(y_d[i]), .side_in(y_side[i]),
            .v_out(y_v[i+1]), .rem_out(y_rem[i+1]), .nq_out(y_nq[i+1]),
            .d_out(y_d[i+1]), .side_out(y_side[i+1])
        );
    end

    // ---------------- stage p: assemble the result word
    sef_pkg::xy_side_t p_in;
    logic              p_lz;
    sef_pkg::sef_out_t p_next;
    logic              p_v_reg;
    sef_pkg::sef_out_t p_data_reg;

    assign p_in = sef_pkg::xy_side_t'(x_side[XySteps]);
    assign p_lz = p_in.len == 33'd0;

    always_comb begin
        p_next.stress_ratio   = p_in.stress;
        p_next.current_length = p_in.len[32] ? 32'hFFFF_FFFF : p_in.len[31:0];
        if (p_in.rz || p_lz) begin
            p_next.force_x = 64'sd0;
            p_next.force_y = 64'sd0;
        end else begin
            p_next.force_x = sef_pkg::sat_force(x_nq[XySteps], p_in.ovf, p_in.negx);
            p_next.force_y = sef_pkg::sat_force(y_nq[XySteps], y_side[XySteps], p_in.negy);
        end
        if (p_in.rz)  p_next.error_code = sef_pkg::ErrRestZero;
        else if (p_lz) p_next.error_code = sef_pkg::ErrLenZero;
        else          p_next.error_code = sef_pkg::ErrNone;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) p_v_reg <= 1'b0;
        else if (en)  p_v_reg <= x_v[XySteps] & y_v[XySteps];
    end

    always_ff @(posedge aclk) begin
        if (en) p_data_reg <= p_next;
    end

    // ---------------- output register with skid
    logic              m_valid_reg, skid_valid_reg;
    sef_pkg::sef_out_t m_data_reg, skid_data_reg;

    // The pipeline only moves while the skid register is empty.
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= p_v_reg;
        end else if (p_v_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (!m_valid_reg || m_ready) m_data_reg <= skid_data_reg;
        end else if (!m_valid_reg || m_ready) begin
            m_data_reg <= p_data_reg;
        end else begin
            skid_data_reg <= p_data_reg;
        end
    end

    // ---------------- assertions
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    a_pipe_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(p_v_reg) && $stable(p_data_reg))
        else $error("pipeline moved while skid register full");

    a_err_no_force : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != sef_pkg::ErrNone
        |-> m_data.force_x == 64'sd0 && m_data.force_y == 64'sd0)
        else $error("nonzero force reported with an error code");

    a_rest_zero_stress : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code == sef_pkg::ErrRestZero |-> m_data.stress_ratio == 32'd0)
        else $error("nonzero stress ratio with zero rest length");

endmodule
